[rtl/sst_pkg.sv]
package sst_pkg;

  localparam int DEST_W   = 10;
  localparam int REF_W    = 12;
  localparam int PE_W     = 11;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [PE_W-1:0] PE_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [REF_W-1:0]  ref_index;
  } in_word_t;

  typedef struct packed {
    logic                is_new;
    logic [STATUS_W-1:0] status;
  } out_word_t;

endpackage

[rtl/sent_set_tracker_unit.sv]
// Channel | Direction | Ports                        | Handshake
// input   | in        | in_start, in_busy, in_word   | taken when start high and busy low
// result  | out       | out_strobe, out_word         | one-cycle strobe, cannot be held off
// config  | in/out    | cfg_psel .. cfg_prdata       | APB-style write, pready always high
//
// After reset the block sweeps the head table and the row pool, one row per cycle,
// over addresses 0 to max(HDEPTH, ROWS) - 1 while busy stays high.
// An item fetches its head entry in S_HEAD and S_HWAIT, visits each row in S_RREAD
// (address), S_RWAIT (registered read) and S_ROW (row update), and closes in S_DONE;
// a fresh reference goes from S_HWAIT to S_DONE, a rejected word from S_IDLE to S_DONE.
// The receiver cannot stall, so the result strobe in the next cycle simply ends the item.
module sent_set_tracker_unit #(
  parameter int REFS     = 4096,
  parameter int ROWS     = 4096,
  parameter int SLOTS    = 8,
  parameter int MAX_DEST = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  output logic                in_busy,
  input  sst_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output sst_pkg::out_word_t  out_word,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import sst_pkg::*;

  // Only references reachable through the ref_index field need a head entry.
  localparam int HDEPTH = (REFS < 2) ? 2 : ((REFS < (1 << REF_W)) ? REFS : (1 << REF_W));
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HW   = $clog2(HDEPTH);
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = (RW > HW) ? RW : HW;
  localparam int CNTW = RW + 1;
  localparam int CLRN = (HDEPTH > ROWS) ? HDEPTH : ROWS;
  // A row word holds SLOTS entries, each a valid bit and a destination, then link.
  localparam int ENTW = 1 + DEST_W;
  localparam int ROWW = SLOTS * ENTW + 1 + RW;
  localparam int HEADW = 1 + RW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HEAD  = 8'b0000_0100,
    S_HWAIT = 8'b0000_1000,
    S_RREAD = 8'b0001_0000,
    S_RWAIT = 8'b0010_0000,
    S_ROW   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [PE_W-1:0]     pe_count_r;
  logic [DEST_W-1:0]   dest_r;
  logic [HW-1:0]       ref_r;
  logic [RW-1:0]       row_r;
  logic [CNTW-1:0]     used_r;
  logic [CNTW-1:0]     steps_r;
  logic                ins_r;          // insertion started, carrying an entry
  logic [DEST_W-1:0]   carry_r;
  logic [CW:0]         clr_r;
  logic                res_new_r;
  logic [STATUS_W-1:0] res_st_r;
  logic                strobe_r;

  // Head table memory.
  logic             h_we;
  logic [HW-1:0]    h_waddr, h_raddr;
  logic [HEADW-1:0] h_wdata, h_rdata;
  // Row memory.
  logic             r_we;
  logic [RW-1:0]    r_waddr, r_raddr;
  logic [ROWW-1:0]  r_wdata, r_rdata;
  // Row write port after the fresh tail write is merged in.
  logic             rp_we;
  logic [RW-1:0]    rp_addr;
  logic [ROWW-1:0]  rp_data;

  sst_ram #(.WIDTH(HEADW), .DEPTH(HDEPTH)) u_head (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  sst_ram #(.WIDTH(ROWW), .DEPTH(ROWS)) u_rows (
    .clk(clk), .we(rp_we), .waddr(rp_addr), .wdata(rp_data),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // Configuration port.
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {{(32-PE_W){1'b0}}, pe_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_count_r <= PE_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr == 2'd0) begin
      pe_count_r <= cfg_pwdata[PE_W-1:0];
    end
  end

  // Row processing: one row word is examined per pass. Before insertion starts,
  // the walk looks for the first slot that is empty or not below dest; once
  // inserting, the carried entry goes into slot 0 and everything ripples.
  logic [DEST_W-1:0] slot_d [SLOTS];
  logic              slot_v [SLOTS];
  logic              link_v;
  logic [RW-1:0]     link_a;
  logic [SW:0]       k_pos;
  logic              found;
  logic              dup;
  logic [ROWW-1:0]   row_new;
  logic              ends_in_empty;
  logic [DEST_W-1:0] out_carry;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_v[i] = r_rdata[i*ENTW + DEST_W];
      slot_d[i] = r_rdata[i*ENTW +: DEST_W];
    end
    link_v = r_rdata[SLOTS*ENTW + RW];
    link_a = r_rdata[SLOTS*ENTW +: RW];
  end

  always_comb begin
    logic [DEST_W-1:0] c;
    logic              shifting;
    k_pos = (SW+1)'(SLOTS);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_v[i] || dest_r <= slot_d[i]) begin
        k_pos = (SW+1)'(i);
      end
    end
    if (ins_r) begin
      k_pos = '0;
    end
    found = (k_pos != (SW+1)'(SLOTS));
    dup = !ins_r && found && slot_v[k_pos[SW-1:0]] && slot_d[k_pos[SW-1:0]] == dest_r;
    row_new = r_rdata;
    c = ins_r ? carry_r : dest_r;
    shifting = 1'b1;
    ends_in_empty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if ((SW+1)'(i) >= k_pos && shifting) begin
        row_new[i*ENTW +: ENTW] = {1'b1, c};
        if (!slot_v[i]) begin
          shifting = 1'b0;
          ends_in_empty = 1'b1;
        end
        c = slot_d[i];
      end
    end
    out_carry = c;
  end

  logic pool_full;
  assign pool_full = (used_r >= CNTW'(ROWS));

  logic bad_in;
  assign bad_in = ({1'b0, in_word.dest} >= pe_count_r)
               || ({16'd0, in_word.dest} >= 26'(MAX_DEST))
               || ({20'd0, in_word.ref_index} >= 32'(REFS));

  always_comb begin
    state_nxt = state_r;
    h_we = 1'b0;
    h_waddr = ref_r;
    h_wdata = {1'b1, used_r[RW-1:0]};
    h_raddr = in_word.ref_index[HW-1:0];
    r_we = 1'b0;
    r_waddr = row_r;
    r_wdata = row_new;
    r_raddr = row_r;
    unique case (state_r)
      S_CLEAR: begin
        h_we = (clr_r < (CW+1)'(HDEPTH));
        h_waddr = clr_r[HW-1:0];
        h_wdata = '0;
        r_we = (clr_r < (CW+1)'(ROWS));
        r_waddr = clr_r[RW-1:0];
        r_wdata = '0;
        if (clr_r == (CW+1)'(CLRN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_start) begin
          state_nxt = bad_in ? S_DONE : S_HEAD;
        end
      end
      S_HEAD: begin
        // The input word may already have moved on, so read from the captured reference.
        h_raddr = ref_r;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        if (!h_rdata[HEADW-1]) begin
          // Fresh chain: first row takes the dest.
          if (!pool_full) begin
            h_we = 1'b1;
            r_we = 1'b1;
            r_waddr = used_r[RW-1:0];
            r_wdata = '0;
            r_wdata[DEST_W] = 1'b1;
            r_wdata[DEST_W-1:0] = dest_r;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RREAD;
        end
      end
      S_RREAD: state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_ROW;
      S_ROW: begin
        if (dup) begin
          state_nxt = S_DONE;
        end else if (steps_r >= CNTW'(ROWS)) begin
          state_nxt = S_DONE;
        end else begin
          if (found) begin
            r_we = 1'b1;
          end
          if (found && ends_in_empty) begin
            state_nxt = S_DONE;
          end else if (!link_v) begin
            if (!pool_full) begin
              r_we = 1'b1;
              r_wdata[SLOTS*ENTW +: RW+1] = {1'b1, used_r[RW-1:0]};
              r_waddr = row_r;
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RREAD;
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // A second row write (the fresh tail) happens in S_DONE on the row port, which is idle then.
  logic             tail_pend_r;
  logic [DEST_W-1:0] tail_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      strobe_r    <= 1'b0;
      tail_pend_r <= 1'b0;
      ins_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      tail_pend_r <= 1'b0;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_start) begin
            dest_r   <= in_word.dest;
            ref_r    <= in_word.ref_index[HW-1:0];
            steps_r  <= '0;
            ins_r    <= 1'b0;
            res_new_r <= 1'b0;
            res_st_r <= ST_RANGE;
          end
        end
        S_HWAIT: begin
          row_r <= h_rdata[RW-1:0];
          res_new_r <= 1'b1;
          if (!h_rdata[HEADW-1]) begin
            res_st_r <= pool_full ? ST_OVERFLOW : ST_OK;
            if (!pool_full) begin
              used_r <= used_r + 1'b1;
            end
          end
        end
        S_ROW: begin
          steps_r <= steps_r + 1'b1;
          if (dup) begin
            res_new_r <= 1'b0;
            res_st_r  <= ST_OK;
          end else if (steps_r >= CNTW'(ROWS)) begin
            res_st_r <= ST_OVERFLOW;
          end else if (found && ends_in_empty) begin
            res_st_r <= ST_OK;
          end else if (!link_v) begin
            res_st_r <= pool_full ? ST_OVERFLOW : ST_OK;
            if (!pool_full) begin
              used_r      <= used_r + 1'b1;
              tail_pend_r <= 1'b1;
              tail_val_r  <= found ? out_carry : dest_r;
              row_r       <= used_r[RW-1:0];
            end
          end else begin
            row_r <= link_a;
            if (found) begin
              ins_r   <= 1'b1;
              carry_r <= out_carry;
            end
          end
        end
        S_DONE: strobe_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // The fresh tail row is written in S_DONE; the row port is otherwise idle then.
  logic             t_we;
  assign t_we = tail_pend_r;

  // Merge tail write into the row port: S_DONE drives no other row write.
  always_comb begin
    rp_we = r_we;
    rp_addr = r_waddr;
    rp_data = r_wdata;
    if (t_we) begin
      rp_we = 1'b1;
      rp_addr = row_r;
      rp_data = '0;
      rp_data[DEST_W] = 1'b1;
      rp_data[DEST_W-1:0] = tail_val_r;
    end
  end

  assign in_busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word.is_new = res_new_r;
  assign out_word.status = res_st_r;

  // Each accepted word produces exactly one strobe.
  a_no_strobe_in_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_start) |=> !out_strobe)
    else $error("strobe raised at start");
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNTW'(ROWS))
    else $error("row pool count beyond pool size");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == S_IDLE)
    else $error("strobe outside idle");

endmodule

[rtl/sst_ram.sv]
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
